// File: rtl/core/mbp_pkg.sv
`default_nettype none
package mbp_pkg;

  localparam int BYTE_BITS         = 8;
  localparam int MAX_CODE_BITS_DEF = 64;
  localparam int LEN_W             = 7;
  localparam int CNT_W             = 4;
  localparam int USED_W            = 3;
  localparam int TOTAL_W           = 8;
  localparam int IN_TDATA_W        = 72;
  localparam int CODE_W            = 64;

  localparam logic [CNT_W-1:0] BYTES_MAX = 4'd8;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef struct packed {
    logic load;
    logic align;
    logic emit;
    logic finish;
  } mbp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic out_free;
  } mbp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/mbp_ctrl.sv
`default_nettype none
module mbp_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire  mbp_pkg::mbp_stat_t stat,
  output mbp_pkg::mbp_cmd_t  cmd
);
  import mbp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.cnt_zero) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // after align, the next command is not a load
  a_emit_after_align: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.align |=> !cmd.load)
    else $error("load right after align");

  // a finished item returns to accepting
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_tready)
    else $error("not ready after finish");

endmodule
`default_nettype wire

// File: rtl/core/mbp_dp.sv
`default_nettype none
module mbp_dp #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          req_type,
  input  wire  [mbp_pkg::CODE_W-1:0]   code_bits,
  input  wire  [mbp_pkg::LEN_W-1:0]    code_length,
  input  wire  mbp_pkg::mbp_cmd_t      cmd,
  output mbp_pkg::mbp_stat_t           stat,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [mbp_pkg::BYTE_BITS-1:0] out_tdata,
  output logic                         out_tlast
);
  import mbp_pkg::*;

  localparam int SH_W = MAX_CODE_BITS + BYTE_BITS;

  logic [MAX_CODE_BITS-1:0] code_al_r;
  logic [LEN_W-1:0]         len_r;
  logic                     req_r;
  logic [SH_W-1:0]          sh_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [USED_W-1:0]        rem_r;
  logic [BYTE_BITS-1:0]     partial_r;
  logic [USED_W-1:0]        used_r;
  logic                     out_valid_r;
  logic [BYTE_BITS-1:0]     out_data_r;
  logic                     out_last_r;

  logic [LEN_W-1:0]   len_sat;
  logic [LEN_W-1:0]   al_shift;
  logic [TOTAL_W-1:0] total;

  // saturate, then left align so bits above the length fall off the top
  assign len_sat  = (code_length > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                           : code_length;
  assign al_shift = LEN_W'(MAX_CODE_BITS) - len_sat;
  assign total    = TOTAL_W'(used_r) + TOTAL_W'(len_r);

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= req_type;
      len_r     <= len_sat;
      code_al_r <= code_bits[MAX_CODE_BITS-1:0] << al_shift;
    end
  end

  // bit string and byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rem_r     <= '0;
      partial_r <= '0;
      used_r    <= '0;
      sh_r      <= '0;
    end else begin
      if (cmd.align) begin
        if (req_r == REQ_FLUSH) begin
          sh_r  <= {partial_r, {MAX_CODE_BITS{1'b0}}};
          cnt_r <= (used_r != '0) ? CNT_W'(1) : '0;
          rem_r <= '0;
        end else begin
          sh_r  <= {partial_r, {MAX_CODE_BITS{1'b0}}}
                 | ({code_al_r, {BYTE_BITS{1'b0}}} >> used_r);
          cnt_r <= total[TOTAL_W-2:USED_W];
          rem_r <= total[USED_W-1:0];
        end
      end else if (cmd.emit) begin
        sh_r  <= sh_r << BYTE_BITS;
        cnt_r <= cnt_r - CNT_W'(1);
      end else if (cmd.finish) begin
        partial_r <= sh_r[SH_W-1 -: BYTE_BITS];
        used_r    <= rem_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= sh_r[SH_W-1 -: BYTE_BITS];
      out_last_r <= (cnt_r == CNT_W'(1));
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= BYTES_MAX)
    else $error("byte count above eight");

  // unused low bits of the pending byte stay zero
  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (partial_r & (8'hFF >> used_r)) == 8'h00)
    else $error("pending byte has stray low bits");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cnt_r == CNT_W'(1)) |=> (out_tvalid && out_tlast))
    else $error("final byte of a transaction not marked last");

endmodule
`default_nettype wire

// File: rtl/core/msb_first_bit_packer.sv
// sequence: accept, align, then one byte per cycle while the output is not stalled
// a transaction completes n bytes (0..8); the next is accepted only after its last byte is emitted
// the single byte output port, one byte per cycle when not stalled, bounds the transaction rate
// reset: synchronous active-low rst_n clears the pending byte, bit count and control
// the output register may hold a byte while the next transaction is accepted
`default_nettype none
module msb_first_bit_packer #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // input stream
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [mbp_pkg::IN_TDATA_W-1:0]  in_tdata,   // [63:0] code_bits, [70:64] code_length
  input  wire                             in_tuser,   // req_type: 0 append, 1 flush
  // byte stream
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [mbp_pkg::BYTE_BITS-1:0]   out_tdata,  // [7:0] out_byte, first code bit in bit 7
  output logic                            out_tlast   // last byte of this transaction
);
  import mbp_pkg::*;

  mbp_cmd_t  cmd;
  mbp_stat_t stat;

  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;

  // unpack the input payload; top bit of tdata is byte padding
  assign code_bits   = in_tdata[CODE_W-1:0];
  assign code_length = in_tdata[CODE_W +: LEN_W];

  // controller: idle -> align -> emit bytes -> idle
  mbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: bit string shifter, pending byte and output register
  mbp_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_type    (in_tuser),
    .code_bits   (code_bits),
    .code_length (code_length),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  // a stalled byte stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output byte changed while stalled");

  // an accepted transaction blocks the next one for at least the align cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted during align");

  // still busy in the cycle after align, while the byte count settles
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> ##1 !in_tready)
    else $error("transaction accepted before byte count settled");

endmodule
`default_nettype wire
